[sv/ttt_pkg.sv]
`default_nettype none
package ttt_pkg;

    localparam int unsigned TTT_ENTRIES_DEF = 16;
    localparam int unsigned S_DATA_W = 200;
    localparam int unsigned S_USER_W = 3;
    localparam int unsigned M_DATA_W = 72;

    typedef enum logic [2:0] {
        CMD_SCHEDULE   = 3'd0,
        CMD_CANCEL_ID  = 3'd1,
        CMD_CANCEL_ALL = 3'd2,
        CMD_PROCESS    = 3'd3,
        CMD_SHIFT      = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_PROC,
        ST_STATUS
    } state_t;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] target;
        logic [31:0] period;
    } entry_t;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic fire;
        logic out_free;
    } dp_stat_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hffff_ffff : s[31:0];
    endfunction

endpackage
`default_nettype wire

[sv/ttt_ctrl.sv]
`default_nettype none
module ttt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire ttt_pkg::dp_stat_t stat,
    output ttt_pkg::ctrl_cmd_t     ctl
);
    import ttt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = stat.scan_done ? ST_STATUS : ST_PROC;
            end
            ST_PROC:
            begin
                if (!stat.fire || stat.out_free)
                begin
                    ctl.step   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_STATUS:
            begin
                if (stat.out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[sv/ttt_datapath.sv]
`default_nettype none
module ttt_datapath #(
    parameter int unsigned TABLE_ENTRIES = ttt_pkg::TTT_ENTRIES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ttt_pkg::ctrl_cmd_t            ctl,
    output ttt_pkg::dp_stat_t                  stat,
    input  wire logic [ttt_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire logic [ttt_pkg::S_USER_W-1:0]  s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [ttt_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);
    import ttt_pkg::*;

    localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

    entry_t mem [TABLE_ENTRIES];
    entry_t rd_reg;

    logic [2:0]    cmd_reg;
    logic [31:0]   now_reg;
    logic [31:0]   tid_reg;
    logic [32:0]   limit_reg;
    logic [31:0]   shift_reg;
    logic [CW-1:0] count_reg, r_reg, w_reg;
    logic [31:0]   next_id_reg;
    logic          found_reg;
    logic          alarm_reg;
    logic [31:0]   best_reg;
    logic [31:0]   st_id_reg;
    logic          st_ok_reg;

    logic          out_valid_reg;
    logic [31:0]   out_id_reg;
    logic          out_ok_reg, out_alarm_reg, out_kind_reg, out_last_reg;
    logic [31:0]   out_wait_reg;

    logic [31:0] in_now, in_tval, in_period, in_tid, in_tol, in_shift;
    logic        in_abs;
    logic [31:0] sched_target;
    logic        full;

    logic        due, drop, id_hit, fire;
    logic [31:0] new_target;
    logic [33:0] shift_sum;

    logic        wr_en;
    logic [IW-1:0] wr_addr;
    entry_t      wr_data;

    assign in_now    = s_tdata[31:0];
    assign in_tval   = s_tdata[63:32];
    assign in_abs    = s_tdata[64];
    assign in_period = s_tdata[96:65];
    assign in_tid    = s_tdata[128:97];
    assign in_tol    = s_tdata[160:129];
    assign in_shift  = s_tdata[192:161];

    assign full         = (count_reg == FULL);
    assign sched_target = in_abs ? in_tval : sat_add(in_now, in_tval);
    assign id_hit       = !found_reg && (rd_reg.id == tid_reg);
    assign due          = ({1'b0, rd_reg.target} <= limit_reg);
    assign shift_sum    = {2'b00, rd_reg.target} + {{2{shift_reg[31]}}, shift_reg};

    always_comb
    begin
        drop       = 1'b0;
        new_target = rd_reg.target;
        fire       = 1'b0;
        case (cmd_reg)
            CMD_CANCEL_ID:
            begin
                drop = id_hit;
            end
            CMD_CANCEL_ALL:
            begin
                drop = 1'b1;
            end
            CMD_PROCESS:
            begin
                fire = due;
                if (due)
                begin
                    if (rd_reg.period != 32'd0)
                    begin
                        new_target = sat_add(now_reg, rd_reg.period);
                    end
                    else
                    begin
                        drop = 1'b1;
                    end
                end
            end
            CMD_SHIFT:
            begin
                if (shift_sum[33])
                begin
                    new_target = 32'd0;
                end
                else if (shift_sum[32])
                begin
                    new_target = 32'hffff_ffff;
                end
                else
                begin
                    new_target = shift_sum[31:0];
                end
            end
            default:
            begin
                drop = 1'b0;
            end
        endcase
    end

    assign stat.fire      = fire;
    assign stat.scan_done = (r_reg == count_reg);
    assign stat.out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = w_reg[IW-1:0];
        wr_data = '{id: rd_reg.id, target: new_target, period: rd_reg.period};
        if (ctl.load)
        begin
            wr_en   = (s_tuser == CMD_SCHEDULE) && !full;
            wr_addr = count_reg[IW-1:0];
            wr_data = '{id: next_id_reg, target: sched_target, period: in_period};
        end
        else if (ctl.step)
        begin
            wr_en = !drop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[r_reg[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= s_tuser;
            now_reg   <= in_now;
            tid_reg   <= in_tid;
            limit_reg <= {1'b0, in_now} + {1'b0, in_tol};
            shift_reg <= in_shift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            r_reg         <= '0;
            w_reg         <= '0;
            next_id_reg   <= '0;
            found_reg     <= 1'b0;
            alarm_reg     <= 1'b0;
            best_reg      <= '0;
            st_id_reg     <= '0;
            st_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= 1'b0;
            out_id_reg    <= '0;
            out_ok_reg    <= 1'b0;
            out_alarm_reg <= 1'b0;
            out_wait_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.emit || (ctl.step && fire))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ctl.load)
            begin
                r_reg     <= '0;
                w_reg     <= '0;
                found_reg <= 1'b0;
                alarm_reg <= 1'b0;
                best_reg  <= '0;
                if (s_tuser == CMD_SCHEDULE && !full)
                begin
                    count_reg   <= count_reg + CW'(1);
                    next_id_reg <= next_id_reg + 32'd1;
                    st_id_reg   <= next_id_reg;
                    st_ok_reg   <= 1'b1;
                end
                else if (s_tuser == CMD_CANCEL_ID)
                begin
                    st_id_reg <= in_tid;
                    st_ok_reg <= 1'b0;
                end
                else
                begin
                    st_id_reg <= '0;
                    st_ok_reg <= 1'b0;
                end
            end
            if (ctl.step)
            begin
                r_reg <= r_reg + CW'(1);
                if (cmd_reg == CMD_CANCEL_ID && id_hit)
                begin
                    found_reg <= 1'b1;
                    st_ok_reg <= 1'b1;
                end
                if (!drop)
                begin
                    w_reg <= w_reg + CW'(1);
                    if (new_target > now_reg && (!alarm_reg || new_target < best_reg))
                    begin
                        best_reg  <= new_target;
                        alarm_reg <= 1'b1;
                    end
                end
                if (fire)
                begin
                    out_kind_reg  <= 1'b1;
                    out_id_reg    <= rd_reg.id;
                    out_ok_reg    <= 1'b0;
                    out_alarm_reg <= 1'b0;
                    out_wait_reg  <= '0;
                    out_last_reg  <= 1'b0;
                end
            end
            if (ctl.emit)
            begin
                count_reg     <= w_reg;
                out_kind_reg  <= 1'b0;
                out_id_reg    <= st_id_reg;
                out_ok_reg    <= st_ok_reg;
                out_alarm_reg <= alarm_reg;
                out_wait_reg  <= alarm_reg ? best_reg - now_reg : 32'd0;
                out_last_reg  <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'd0, out_wait_reg, out_alarm_reg, out_ok_reg, out_id_reg};

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("entry count beyond table size");

    a_write_behind_read: assert property (@(posedge clk) disable iff (!rst_n)
        w_reg <= r_reg)
        else $error("compaction write index passed read index");

    a_fire_only_process: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step && fire |-> cmd_reg == CMD_PROCESS)
        else $error("fired record outside process command");

    a_out_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> out_valid_reg)
        else $error("pending result dropped");

endmodule
`default_nettype wire

[sv/timed_task_table.sv]
// a command scans all active entries present before it (schedule counts the new entry),
// and an output stall can hold it
// one command at a time; the table scan reads one entry and processes it before reading
// the next, from a table with one write port and one registered read port
// reset: asynchronous active low, empties the table and clears the id counter
`default_nettype none
module timed_task_table #(
    parameter int unsigned TABLE_ENTRIES = ttt_pkg::TTT_ENTRIES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // now_time, time_value, is_absolute, repeat_interval, target_id, tolerance, time_shift
    input  wire logic [ttt_pkg::S_DATA_W-1:0]  s_tdata,
    // cmd
    input  wire logic [ttt_pkg::S_USER_W-1:0]  s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // task_id, ok, alarm_set, wait_seconds
    output logic [ttt_pkg::M_DATA_W-1:0]       m_tdata,
    // kind
    output logic                               m_tuser,
    output logic                               m_tlast
);
    import ttt_pkg::*;

    ctrl_cmd_t ctl;
    dp_stat_t  stat;

    ttt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    ttt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire
